// ===== rtl/word_crc_response_deframer_defines.svh =====
// assertion helpers shared by the deframer
`ifndef WORD_CRC_RESPONSE_DEFRAMER_DEFINES_SVH
`define WORD_CRC_RESPONSE_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WCRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define WCRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wcrd_pkg.sv =====
`timescale 1ns / 1ps

package wcrd_pkg;

	localparam int FRAME_BYTES = 24;
	localparam logic [3:0] WORDS_CAP = 4'(FRAME_BYTES / 3);

	localparam logic [7:0] POLY_RESET  = 8'h31;
	localparam logic [7:0] INIT_RESET  = 8'hFF;
	localparam logic [3:0] WORDS_RESET = 4'd4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CFG_CRC_POLY   = 2'd0,
		CFG_CRC_INIT   = 2'd1,
		CFG_WORDS_USED = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] word;
		logic [2:0]  index;
		logic        ok;
		logic        last;
	} entry_t;

	// one byte through the crc register, msb first
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/wcrd_front.sv =====
`timescale 1ns / 1ps

module wcrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic                queue_full,
	output logic                push,
	output wcrd_pkg::entry_t    entry
);

	logic [7:0] poly_q;
	logic [7:0] init_q;
	logic [3:0] words_used_q;

	wcrd_pkg::phase_t phase_q, phase_d, phase_start;
	logic [3:0] wc_q, wc_d, wc_start;
	logic [7:0] high_q, high_d;
	logic [7:0] low_q, low_d;
	logic [7:0] crc_q, crc_d;
	logic [3:0] limit;
	logic       accept;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q       <= wcrd_pkg::POLY_RESET;
			init_q       <= wcrd_pkg::INIT_RESET;
			words_used_q <= wcrd_pkg::WORDS_RESET;
		end else if (cfg_we) begin
			unique case (wcrd_pkg::cfg_idx_t'(cfg_index))
				wcrd_pkg::CFG_CRC_POLY:   poly_q       <= cfg_data;
				wcrd_pkg::CFG_CRC_INIT:   init_q       <= cfg_data;
				wcrd_pkg::CFG_WORDS_USED: words_used_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign limit = (words_used_q > wcrd_pkg::WORDS_CAP) ? wcrd_pkg::WORDS_CAP : words_used_q;

	always_comb begin
		phase_start = frame_start ? wcrd_pkg::PH_HIGH : phase_q;
		wc_start    = frame_start ? 4'd0 : wc_q;
		phase_d     = phase_q;
		wc_d        = wc_q;
		high_d      = high_q;
		low_d       = low_q;
		crc_d       = crc_q;
		push        = 1'b0;
		if (accept) begin
			phase_d = phase_start;
			wc_d    = wc_start;
			// bytes past the reported words only matter for a new frame start
			if (wc_start < limit) begin
				unique case (phase_start)
					wcrd_pkg::PH_HIGH: begin
						high_d  = rx_byte;
						crc_d   = wcrd_pkg::crc_feed(init_q, rx_byte, poly_q);
						phase_d = wcrd_pkg::PH_LOW;
					end
					wcrd_pkg::PH_LOW: begin
						low_d   = rx_byte;
						crc_d   = wcrd_pkg::crc_feed(crc_q, rx_byte, poly_q);
						phase_d = wcrd_pkg::PH_CRC;
					end
					wcrd_pkg::PH_CRC: begin
						push    = 1'b1;
						phase_d = wcrd_pkg::PH_HIGH;
						wc_d    = wc_start + 4'd1;
					end
					default: phase_d = wcrd_pkg::PH_HIGH;
				endcase
			end
		end
	end

	assign entry.word  = {high_q, low_q};
	assign entry.index = wc_start[2:0];
	assign entry.ok    = (crc_q == rx_byte);
	assign entry.last  = ((wc_start + 4'd1) == limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wcrd_pkg::PH_HIGH;
			wc_q    <= 4'd0;
		end else begin
			phase_q <= phase_d;
			wc_q    <= wc_d;
		end
	end

	always_ff @(posedge clk) begin
		high_q <= high_d;
		low_q  <= low_d;
		crc_q  <= crc_d;
	end

endmodule

// ===== rtl/wcrd_queue.sv =====
`timescale 1ns / 1ps

module wcrd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wcrd_pkg::entry_t    push_entry,
	output logic                full,
	output logic                valid,
	input  logic                pop,
	output wcrd_pkg::entry_t    head
);

	wcrd_pkg::entry_t mem_q [wcrd_pkg::QUEUE_DEPTH];
	logic [wcrd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [wcrd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [wcrd_pkg::QCNT_W-1:0] count_q;

	assign full  = (count_q == wcrd_pkg::QCNT_W'(wcrd_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == wcrd_pkg::QPTR_W'(wcrd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == wcrd_pkg::QPTR_W'(wcrd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wcrd_back.sv =====
`timescale 1ns / 1ps

module wcrd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  wcrd_pkg::entry_t    head,
	output logic                pop,
	output logic                sample_valid,
	input  logic                sample_stall,
	output logic [15:0]         sample_value,
	output logic [2:0]          sample_index,
	output logic                crc_ok,
	output logic                last,
	output logic                frame_error
);

	logic        out_valid_q;
	logic [15:0] value_q;
	logic [2:0]  index_q;
	logic        ok_q;
	logic        last_q;
	logic        ferr_q;
	logic        zero_seen_q;

	logic [15:0] value;
	logic        zero_acc;

	assign pop      = head_valid && (!out_valid_q || !sample_stall);
	assign value    = head.ok ? head.word : 16'd0;
	// first word of a frame restarts the zero tracking
	assign zero_acc = ((head.index == 3'd0) ? 1'b0 : zero_seen_q) || (value == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			zero_seen_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				zero_seen_q <= zero_acc;
			end else if (!sample_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= value;
			index_q <= head.index;
			ok_q    <= head.ok;
			last_q  <= head.last;
			ferr_q  <= head.last && zero_acc;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample_value = value_q;
	assign sample_index = index_q;
	assign crc_ok       = ok_q;
	assign last         = last_q;
	assign frame_error  = ferr_q;

endmodule

// ===== rtl/word_crc_response_deframer.sv =====
`timescale 1ns / 1ps
// Response deframer: checks the crc-8 of each (high, low, crc) byte triple.
// Byte channel: rx_byte and frame_start move on byte_valid with byte_stall low;
// frame_start marks the first byte of a frame. Sample channel: one transfer
// per checked word on sample_valid with sample_stall low, carrying the word
// (zero on a crc mismatch), its index, crc_ok, last and frame_error.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 polynomial,
// 1 crc start value, 2 words per frame); the user must write only while the
// block is idle, as the block does not enforce it. Throughput: one byte per
// cycle while byte_stall is low, so one word per three bytes; words held back
// by a sample stall leave on consecutive cycles once it clears. A word passes
// from the transfer of its crc byte through the two-entry word queue and then
// the output register. The crc of each data byte is folded in as the byte
// arrives, so the check itself is a single compare against the crc byte.
// A stall on the sample side fills the queue; byte_stall rises only while the
// queue is full, and no result is lost.
// Reset: configuration returns to 0x31 / 0xFF / 4 words and the block acts as
// if a frame had just started.

`include "word_crc_response_deframer_defines.svh"

module word_crc_response_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        sample_valid,
	input  logic        sample_stall,
	output logic [15:0] sample_value,
	output logic [2:0]  sample_index,
	output logic        crc_ok,
	output logic        last,
	output logic        frame_error
);

	logic             push;
	logic             queue_full;
	logic             head_valid;
	logic             pop;
	wcrd_pkg::entry_t push_entry;
	wcrd_pkg::entry_t head;

	wcrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.queue_full  (queue_full),
		.push        (push),
		.entry       (push_entry)
	);

	wcrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.valid      (head_valid),
		.pop        (pop),
		.head       (head)
	);

	wcrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.sample_index (sample_index),
		.crc_ok       (crc_ok),
		.last         (last),
		.frame_error  (frame_error)
	);

	`WCRD_ASSERT_NOW(a_no_push_when_full, push, !queue_full, "word pushed into a full queue")
	`WCRD_ASSERT_NOW(a_ferr_only_on_last, sample_valid && frame_error, last, "frame error off last word")
	`WCRD_ASSERT_NOW(a_bad_crc_zero, sample_valid && !crc_ok, sample_value == 16'd0, "bad crc word not zeroed")
	`WCRD_ASSERT_NEXT(a_pop_shows_sample, pop, sample_valid, "popped word not presented")

endmodule

// ===== bench/tb_word_crc_response_deframer.sv =====
`timescale 1ns / 1ps

module tb_word_crc_response_deframer;
	import wcrd_pkg::*;

	localparam int ITEMS        = 1150;
	localparam int PHASES       = 8;
	localparam int DRAIN_CYCLES = 6;
	localparam int SCRIPT_LEN   = 26;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  index;
		logic        ok;
		logic        last;
		logic        ferr;
	} sample_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_GOOD_CRC,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t  idx;
		logic [7:0] val;
		logic      fs;
		logic      typed;
		sample_t   exp;
	} drow_t;

	localparam sample_t NO_SAMPLE = '0;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic        sample_valid;
	logic        sample_stall;
	logic [15:0] sample_value;
	logic [2:0]  sample_index;
	logic        crc_ok;
	logic        last;
	logic        frame_error;

	word_crc_response_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.rx_byte(rx_byte),
		.frame_start(frame_start),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_value(sample_value),
		.sample_index(sample_index),
		.crc_ok(crc_ok),
		.last(last),
		.frame_error(frame_error)
	);

	// predictor state and its copy of the registers
	logic [7:0] poly_m;
	logic [7:0] init_m;
	logic [3:0] wused_m;
	phase_t     ph_m;
	logic [3:0] words_done;
	logic [7:0] hi_m;
	logic [7:0] lo_m;
	logic       zero_seen;

	sample_t pending_samples[$];
	int      taken_bytes;
	int      cyc;
	bit      failed;
	wire     calm = (cyc >= 900 && cyc < 1300);

	// directed part: no frame start before the first frame, crc mismatch,
	// genuine zero word, restart mid-triple, trailing bytes, one word and no words
	drow_t script [SCRIPT_LEN] = '{
		'{ROW_BYTE, CFG_CRC_POLY, 8'hBE, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hEF, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h92, 1'b0, 1'b1, '{16'hBEEF, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hBE, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hEF, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h00, 1'b0, 1'b1, '{16'h0000, 3'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_GOOD_CRC, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hBE, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hEF, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h92, 1'b0, 1'b1, '{16'hBEEF, 3'd3, 1'b1, 1'b1, 1'b1}},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hFF, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h11, 1'b1, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h22, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h33, 1'b1, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h44, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_GOOD_CRC, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_CFG, CFG_WORDS_USED, 8'h01, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hFF, 1'b1, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hFF, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_GOOD_CRC, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_CFG, CFG_WORDS_USED, 8'h00, 1'b0, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'h5A, 1'b1, 1'b0, NO_SAMPLE},
		'{ROW_BYTE, CFG_CRC_POLY, 8'hA5, 1'b0, 1'b0, NO_SAMPLE}
	};

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (r[7]) r = {r[6:0], 1'b0} ^ poly_m;
			else r = {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [3:0] word_limit();
		return (wused_m < WORDS_CAP) ? wused_m : WORDS_CAP;
	endfunction

	// steps the predictor by one byte, returns 1 when a sample is due
	function automatic bit fold_byte(input logic [7:0] b, input logic fs, output sample_t s);
		logic [3:0]  lim;
		logic [15:0] w;
		logic        ok;
		s = '0;
		if (fs) begin
			ph_m = PH_HIGH;
			words_done = '0;
			zero_seen = 1'b0;
		end
		lim = word_limit();
		if (words_done >= lim) return 1'b0;
		taken_bytes++;
		case (ph_m)
			PH_HIGH: begin
				hi_m = b;
				ph_m = PH_LOW;
				return 1'b0;
			end
			PH_LOW: begin
				lo_m = b;
				ph_m = PH_CRC;
				return 1'b0;
			end
			default: begin
				ok = (crc_byte(crc_byte(init_m, hi_m), lo_m) == b);
				w = ok ? {hi_m, lo_m} : 16'h0000;
				if (w == 16'h0000) zero_seen = 1'b1;
				s.value = w;
				s.index = words_done[2:0];
				s.ok = ok;
				s.last = (4'(words_done + 4'd1) == lim);
				s.ferr = s.last & zero_seen;
				ph_m = PH_HIGH;
				words_done = words_done + 4'd1;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fs, input logic typed = 1'b0,
		input sample_t exp = '0);
		sample_t s;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 21) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= fs;
		do @(posedge clk); while (byte_stall);
		if (fold_byte(b, fs, s)) pending_samples.push_back(typed ? exp : s);
	endtask

	// idle the byte side and let every sample out, plus the tail of a dropped byte
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [7:0] data);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_CRC_POLY: poly_m = data;
			CFG_CRC_INIT: init_m = data;
			CFG_WORDS_USED: wused_m = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames, some cut short, some with trailing bytes
	task automatic send_frame();
		logic [3:0] lim;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] ck;
		int         nw;
		int         tail;
		lim = word_limit();
		nw = lim;
		tail = 0;
		if ($urandom_range(7) == 0) begin
			nw = $urandom_range(lim - 1, 0);
			tail = $urandom_range(2);
		end else if ($urandom_range(3) == 0) begin
			tail = $urandom_range(4, 1);
		end
		for (int k = 0; k < nw; k++) begin
			hi = 8'($urandom);
			lo = 8'($urandom);
			if ($urandom_range(9) == 0) {hi, lo} = 16'h0000;
			else if ($urandom_range(15) == 0) {hi, lo} = 16'hFFFF;
			ck = crc_byte(crc_byte(init_m, hi), lo);
			if ($urandom_range(6) == 0) ck = ck ^ 8'($urandom_range(255, 1));
			send_byte(hi, k == 0);
			send_byte(lo, 1'b0);
			send_byte(ck, 1'b0);
		end
		for (int t = 0; t < tail; t++) send_byte(8'($urandom), nw == 0 && t == 0);
	endtask

	task automatic check_field(input string name, input int e, input int a);
		if (e != a) begin
			$display("%0t %s mismatch: expected %0h, got %0h", $time, name, e, a);
			failed = 1'b1;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	always @(posedge clk) begin : sample_check
		sample_t e;
		if (arst_n && sample_valid && !sample_stall) begin
			if (pending_samples.size() == 0) begin
				$display("%0t unexpected sample: expected none, got value %0h index %0d",
					$time, sample_value, sample_index);
				failed = 1'b1;
			end else begin
				e = pending_samples.pop_front();
				check_field("sample_value", e.value, sample_value);
				check_field("sample_index", e.index, sample_index);
				check_field("crc_ok", e.ok, crc_ok);
				check_field("last", e.last, last);
				check_field("frame_error", e.ferr, frame_error);
			end
		end
	end

	// sample side: random stalls, two long hold-offs to back the block up
	initial begin
		int hold_left;
		int rx_cyc;
		hold_left = 0;
		rx_cyc = 0;
		sample_stall = 1'b0;
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (rx_cyc == 400 || rx_cyc == 1500) hold_left = 80;
			if (hold_left > 0) begin
				hold_left--;
				sample_stall <= 1'b1;
			end else begin
				sample_stall <= !calm && ($urandom_range(99) < 21);
			end
		end
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int         base;
		logic [7:0] pv;
		logic [7:0] iv;
		logic [7:0] wv;
		cyc = 0;
		failed = 1'b0;
		taken_bytes = 0;
		byte_valid = 1'b0;
		rx_byte = '0;
		frame_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CRC_POLY;
		cfg_data = '0;
		poly_m = POLY_RESET;
		init_m = INIT_RESET;
		wused_m = WORDS_RESET;
		ph_m = PH_HIGH;
		words_done = '0;
		hi_m = '0;
		lo_m = '0;
		zero_seen = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_CFG: cfg_write(script[i].idx, script[i].val);
				ROW_GOOD_CRC: send_byte(crc_byte(crc_byte(init_m, hi_m), lo_m), 1'b0,
					script[i].typed, script[i].exp);
				default: send_byte(script[i].val, script[i].fs, script[i].typed, script[i].exp);
			endcase
		end

		base = taken_bytes;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin pv = 8'h31; iv = 8'hFF; wv = 8'h04; end
				1: begin pv = 8'h00; iv = 8'h00; wv = 8'h01; end
				2: begin pv = 8'hFF; iv = 8'hFF; wv = 8'h08; end
				// words_used above the cap, upper nibble of the data bus random
				3: begin pv = 8'h07; iv = 8'h00; wv = {4'($urandom), 4'hF}; end
				default: begin
					pv = 8'($urandom);
					iv = 8'($urandom);
					wv = {4'($urandom), 4'($urandom_range(8, 1))};
				end
			endcase
			cfg_write(CFG_CRC_POLY, pv);
			cfg_write(CFG_CRC_INIT, iv);
			cfg_write(CFG_WORDS_USED, wv);
			while (taken_bytes < base + (p + 1) * ITEMS / PHASES) begin
				if ($urandom_range(11) == 0) begin
					repeat ($urandom_range(6, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
				end else begin
					send_frame();
				end
			end
		end

		settle();
		if (!failed) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wcrd_pkg.sv
rtl/wcrd_front.sv
rtl/wcrd_queue.sv
rtl/wcrd_back.sv
rtl/word_crc_response_deframer.sv
bench/tb_word_crc_response_deframer.sv
